// File: sv/seven_channel_moving_average_top_defines.svh
// assertion macros shared by the moving average rtl
`ifndef SEVEN_CHANNEL_MOVING_AVERAGE_TOP_DEFINES_SVH
`define SEVEN_CHANNEL_MOVING_AVERAGE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// the property holds in the same cycle
`define MSA_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("moving average check failed");
// the property holds in the next cycle
`define MSA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("moving average check failed");
`else
`define MSA_ASSERT_NOW(label, clk, rst, pre, post)
`define MSA_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// File: sv/msa_pkg.sv
// types and constants shared by the moving average block
package msa_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int NUM_FIELDS = 7;
   localparam int GYRO_FIRST = 3;
   localparam int GYRO_AXES  = 3;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_OFFSET_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_OFFSET_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_OFFSET_Z = 2'd2;

   typedef struct packed {
      logic                       sample_valid;
      logic signed [SAMPLE_W-1:0] accel_x;
      logic signed [SAMPLE_W-1:0] accel_y;
      logic signed [SAMPLE_W-1:0] accel_z;
      logic signed [SAMPLE_W-1:0] gyro_x;
      logic signed [SAMPLE_W-1:0] gyro_y;
      logic signed [SAMPLE_W-1:0] gyro_z;
      logic signed [SAMPLE_W-1:0] temperature;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] avg_accel_x;
      logic signed [SAMPLE_W-1:0] avg_accel_y;
      logic signed [SAMPLE_W-1:0] avg_accel_z;
      logic signed [SAMPLE_W-1:0] avg_gyro_x;
      logic signed [SAMPLE_W-1:0] avg_gyro_y;
      logic signed [SAMPLE_W-1:0] avg_gyro_z;
      logic signed [SAMPLE_W-1:0] avg_temperature;
   } rsp_payload_type;

   // pipeline advance strobes and the fresh flag of the items concerned
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic load_c;
      logic load_d;
      logic fresh;
      logic c_fresh;
   } lane_ctrl_type;

endpackage

// File: sv/seven_channel_moving_average_top.sv
// seven channel moving average: handshake control, lanes, offsets and merge
//
// req channel: one transfer per sensor poll, seven signed samples and a
// sample_valid flag. a set flag shifts the samples into each channel's window
// of WINDOW_LENGTH and updates that channel's average (window sum / length,
// truncated toward zero); a clear flag only reads the stored averages.
// rsp channel: one transfer per request, the seven averages with the gyro
// offsets subtracted and saturated.
// csr channel: writes gyro offsets x, y, z at index 0, 1, 2; csr_ready is
// always high and other indexes are dropped. write only while idle.
// pipeline: a result is valid once its request has passed five registered
// stages (window and running sum, reciprocal multiply, remainder, correction,
// merge register). throughput: one request per cycle while req_stall is low,
// set by the running-sum update in each lane.
// rsp_stall holds the result register; bubbles in the five-stage pipeline
// are still filled, and req_stall rises once every stage is occupied.
// reset: synchronous, clears windows, sums, averages, offsets and valids.
`include "seven_channel_moving_average_top_defines.svh"

module seven_channel_moving_average_top
   import msa_pkg::*;
#(
   parameter int WINDOW_LENGTH = 10,
   parameter int CHANNEL_COUNT = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic signed [SAMPLE_W-1:0] csr_data
);

   logic va_ff, vb_ff, vc_ff, vd_ff, vo_ff;
   logic va_in, vb_in, vc_in, vd_in, vo_in;
   logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;
   logic sv_a_ff, sv_b_ff, sv_c_ff;
   lane_ctrl_type ctrl;

   logic signed [SAMPLE_W-1:0] gyro_offset_ff [GYRO_AXES];
   logic signed [SAMPLE_W-1:0] gyro_offset_in [GYRO_AXES];
   logic signed [SAMPLE_W-1:0] sample_field [NUM_FIELDS];
   logic signed [SAMPLE_W-1:0] lane_avg [CHANNEL_COUNT];
   logic signed [SAMPLE_W-1:0] chan_avg [NUM_FIELDS];

   // pipeline flow: a stage takes a transfer when empty or when it drains
   assign rdy_o = !vo_ff || !rsp_stall;
   assign rdy_d = !vd_ff || rdy_o;
   assign rdy_c = !vc_ff || rdy_d;
   assign rdy_b = !vb_ff || rdy_c;
   assign rdy_a = !va_ff || rdy_b;

   assign ctrl.load_a  = req_valid && rdy_a;
   assign ctrl.load_b  = va_ff && rdy_b;
   assign ctrl.load_c  = vb_ff && rdy_c;
   assign ctrl.load_d  = vc_ff && rdy_d;
   assign ctrl.fresh   = req_data.sample_valid;
   assign ctrl.c_fresh = sv_c_ff;

   assign va_in = ctrl.load_a || (va_ff && !ctrl.load_b);
   assign vb_in = ctrl.load_b || (vb_ff && !ctrl.load_c);
   assign vc_in = ctrl.load_c || (vc_ff && !ctrl.load_d);
   assign vd_in = ctrl.load_d || (vd_ff && !(vd_ff && rdy_o));
   assign vo_in = (vd_ff && rdy_o) || (vo_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
         vd_ff <= vd_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_a) begin
         sv_a_ff <= req_data.sample_valid;
      end
      if (ctrl.load_b) begin
         sv_b_ff <= sv_a_ff;
      end
      if (ctrl.load_c) begin
         sv_c_ff <= sv_b_ff;
      end
   end

   assign req_stall = !rdy_a;
   assign rsp_valid = vo_ff;

   // offset registers
   assign csr_ready = 1'b1;

   always_comb begin
      gyro_offset_in = gyro_offset_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GYRO_OFFSET_X: gyro_offset_in[0] = csr_data;
            CSR_GYRO_OFFSET_Y: gyro_offset_in[1] = csr_data;
            CSR_GYRO_OFFSET_Z: gyro_offset_in[2] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_offset_ff <= '{default: '0};
      end else begin
         gyro_offset_ff <= gyro_offset_in;
      end
   end

   assign sample_field[0] = req_data.accel_x;
   assign sample_field[1] = req_data.accel_y;
   assign sample_field[2] = req_data.accel_z;
   assign sample_field[3] = req_data.gyro_x;
   assign sample_field[4] = req_data.gyro_y;
   assign sample_field[5] = req_data.gyro_z;
   assign sample_field[6] = req_data.temperature;

   for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_lane
      logic signed [SAMPLE_W-1:0] lane_sample;
      if (c < NUM_FIELDS) begin : g_fed
         assign lane_sample = sample_field[c];
      end else begin : g_spare
         // channels past the sample fields take in zero
         assign lane_sample = '0;
      end
      msa_lane #(
         .WINDOW_LENGTH(WINDOW_LENGTH)
      ) u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .fresh_sample (lane_sample),
         .avg          (lane_avg[c])
      );
   end

   for (genvar c = 0; c < NUM_FIELDS; c++) begin : g_chan
      if (c < CHANNEL_COUNT) begin : g_live
         assign chan_avg[c] = lane_avg[c];
      end else begin : g_absent
         assign chan_avg[c] = '0;
      end
   end

   msa_merge u_merge (
      .clock       (clock),
      .load        (vd_ff && rdy_o),
      .chan_avg    (chan_avg),
      .gyro_offset (gyro_offset_ff),
      .rsp_data    (rsp_data)
   );

   `MSA_ASSERT_NOW(a_full_stalls, clock, reset, va_ff && vb_ff && vc_ff && vd_ff && vo_ff && rsp_stall, req_stall)
   `MSA_ASSERT_NOW(a_empty_open, clock, reset, !va_ff, !req_stall)
   `MSA_ASSERT_NOW(a_rsp_source, clock, reset, $rose(vo_ff), $past(vd_ff))

endmodule

// File: sv/msa_lane.sv
// one channel: sample window, running sum and divide-by-window pipeline
`include "seven_channel_moving_average_top_defines.svh"

module msa_lane
   import msa_pkg::*;
#(
   parameter int WINDOW_LENGTH = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lane_ctrl_type              ctrl,
   input  logic signed [SAMPLE_W-1:0] fresh_sample,
   output logic signed [SAMPLE_W-1:0] avg
);

   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LENGTH);
   localparam int SHIFT = SUM_W;
   localparam int QW    = SAMPLE_W + 1;
   localparam int RW    = $clog2(WINDOW_LENGTH) + 1;
   localparam int PW    = 2 * SUM_W;
   localparam logic [SHIFT-1:0] RECIP = SHIFT'((64'd1 << SHIFT) / WINDOW_LENGTH);

   logic signed [SAMPLE_W-1:0] hist_ff [WINDOW_LENGTH];
   logic signed [SAMPLE_W-1:0] hist_in [WINDOW_LENGTH];
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SUM_W-1:0]    a_sum_ff;
   logic [SUM_W-1:0]           b_mag_in, b_mag_ff;
   logic [PW-1:0]              b_prod_in, b_prod_ff;
   logic                       b_neg_ff;
   logic [QW-1:0]              c_q_in, c_q_ff;
   logic [SUM_W-1:0]           c_rem_full;
   logic [RW-1:0]              c_rem_ff;
   logic                       c_neg_ff;
   logic [QW-1:0]              d_q, d_q_neg;
   logic signed [SAMPLE_W-1:0] avg_new;
   logic signed [SAMPLE_W-1:0] avg_ff, avg_in;
   logic signed [SAMPLE_W-1:0] d_avg_ff;

   // window shift and running sum update
   always_comb begin
      hist_in = hist_ff;
      sum_in  = sum_ff;
      if (ctrl.load_a && ctrl.fresh) begin
         for (int k = 0; k < WINDOW_LENGTH - 1; k++) begin
            hist_in[k] = hist_ff[k+1];
         end
         hist_in[WINDOW_LENGTH-1] = fresh_sample;
         sum_in = sum_ff + SUM_W'(fresh_sample) - SUM_W'(hist_ff[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '{default: '0};
         sum_ff  <= '0;
      end else begin
         hist_ff <= hist_in;
         sum_ff  <= sum_in;
      end
   end

   // magnitude times reciprocal, at most one short of the true quotient
   assign b_mag_in  = a_sum_ff[SUM_W-1] ? SUM_W'(-a_sum_ff) : SUM_W'(a_sum_ff);
   assign b_prod_in = PW'(b_mag_in) * PW'(RECIP);

   assign c_q_in     = b_prod_ff[SHIFT+QW-1:SHIFT];
   assign c_rem_full = b_mag_ff - SUM_W'(c_q_in) * SUM_W'(WINDOW_LENGTH);

   assign d_q     = c_q_ff + QW'(c_rem_ff >= RW'(WINDOW_LENGTH));
   assign d_q_neg = -d_q;
   assign avg_new = c_neg_ff ? d_q_neg[SAMPLE_W-1:0] : d_q[SAMPLE_W-1:0];
   assign avg_in  = (ctrl.load_d && ctrl.c_fresh) ? avg_new : avg_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load_a) begin
         a_sum_ff <= sum_in;
      end
      if (ctrl.load_b) begin
         b_mag_ff  <= b_mag_in;
         b_prod_ff <= b_prod_in;
         b_neg_ff  <= a_sum_ff[SUM_W-1];
      end
      if (ctrl.load_c) begin
         c_q_ff   <= c_q_in;
         c_rem_ff <= c_rem_full[RW-1:0];
         c_neg_ff <= b_neg_ff;
      end
      if (ctrl.load_d) begin
         d_avg_ff <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff <= '0;
      end else begin
         avg_ff <= avg_in;
      end
   end

   assign avg = d_avg_ff;

   `MSA_ASSERT_NEXT(a_sum_held, clock, reset, ctrl.load_a && !ctrl.fresh, $stable(sum_ff))
   `MSA_ASSERT_NEXT(a_avg_held, clock, reset, !(ctrl.load_d && ctrl.c_fresh), $stable(avg_ff))
   `MSA_ASSERT_NEXT(a_avg_copy, clock, reset, ctrl.load_d, d_avg_ff == avg_ff)

endmodule

// File: sv/msa_merge.sv
// merges the lane averages, applies gyro offsets and holds the result register
module msa_merge
   import msa_pkg::*;
(
   input  logic                       clock,
   input  logic                       load,
   input  logic signed [SAMPLE_W-1:0] chan_avg [NUM_FIELDS],
   input  logic signed [SAMPLE_W-1:0] gyro_offset [GYRO_AXES],
   output rsp_payload_type            rsp_data
);

   logic signed [SAMPLE_W-1:0] field_val [NUM_FIELDS];
   rsp_payload_type            rsp_in, rsp_ff;

   for (genvar c = 0; c < NUM_FIELDS; c++) begin : g_field
      if (c >= GYRO_FIRST && c < GYRO_FIRST + GYRO_AXES) begin : g_gyro
         logic signed [SAMPLE_W:0] diff;
         assign diff = (SAMPLE_W+1)'(chan_avg[c]) - (SAMPLE_W+1)'(gyro_offset[c-GYRO_FIRST]);
         // clamp when the top two bits disagree
         always_comb begin
            if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
               field_val[c] = diff[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                             : {1'b0, {(SAMPLE_W-1){1'b1}}};
            end else begin
               field_val[c] = diff[SAMPLE_W-1:0];
            end
         end
      end else begin : g_plain
         assign field_val[c] = chan_avg[c];
      end
   end

   always_comb begin
      rsp_in.avg_accel_x     = field_val[0];
      rsp_in.avg_accel_y     = field_val[1];
      rsp_in.avg_accel_z     = field_val[2];
      rsp_in.avg_gyro_x      = field_val[3];
      rsp_in.avg_gyro_y      = field_val[4];
      rsp_in.avg_gyro_z      = field_val[5];
      rsp_in.avg_temperature = field_val[6];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
